/* rtl/atws_pkg.sv */
// ----------------------------------------------------------------------------
// atws_pkg: shared types and constants for the alias table weighted sampler
// Holds the command and status codes, the word formats and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package atws_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int PROB_BITS   = 16;
  localparam int WGT_W       = PROB_BITS + 1;
  localparam int SW_W        = WGT_W + CNT_W - 1;
  localparam int VAL_W       = 32;
  localparam int RIX_W       = 16;
  localparam int DIV_CNT_W   = $clog2(RIX_W);

  localparam logic [WGT_W-1:0] ONE_Q = WGT_W'(1) << PROB_BITS;

  // Command codes.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [IDX_W-1:0]     entry_index;
    logic [WGT_W-1:0]     entry_weight;
    logic [VAL_W-1:0]     entry_value;
    logic [RIX_W-1:0]     rand_index;
    logic [PROB_BITS-1:0] rand_frac;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] picked_index;
    logic [VAL_W-1:0] picked_value;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_A_RD,
    S_A_EV,
    S_B_RD,
    S_B_EV,
    S_B_J,
    S_B_G,
    S_FIN,
    S_DIV,
    S_SMP_RD,
    S_SMP_PICK,
    S_SMP_OUT
  } state_e;

endpackage

`default_nettype wire

/* rtl/atws_ram.sv */
// ----------------------------------------------------------------------------
// atws_ram: generic simple dual port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module atws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/alias_table_weighted_sampler.sv */
// ----------------------------------------------------------------------------
// alias_table_weighted_sampler: weighted sampler using the alias method
// Loads weights and payload words, packs threshold and alias tables, draws.
// ----------------------------------------------------------------------------
// A load, a command code 3 and a sample before a build are answered in the
// cycle after start_i. A sample runs a one-bit-per-cycle remainder unit that
// reduces rand_index modulo the entry count, then a threshold and alias read
// and a payload read through the table memories. A build walks the tables
// with one memory access in flight: it copies the weights, then alternates
// fixing passes with distribution passes that run a donor scan for each heavy
// entry (up to n steps each), and ends with a final fill, where n is the
// entry count. busy_o is high for the whole of a sample or build. Each word
// on result_o is valid for exactly one cycle with result_valid_o; the
// receiver cannot stall it. The next word may be started while a result is
// shown.
`default_nettype none

module alias_table_weighted_sampler
  import atws_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire in_word_t         word_i,
  output      logic             busy_o,
  output      out_word_t        result_o,
  output      logic             result_valid_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic                   built_q, built_d;
  logic [MAX_ENTRIES-1:0] fixed_q, fixed_d;
  logic [MAX_ENTRIES-1:0] aset_q, aset_d;
  logic [CNT_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]       j_q, j_d;
  logic                   newly_q, newly_d;
  logic [SW_W-1:0]        remi_q, remi_d;
  logic [RIX_W-1:0]       rix_q, rix_d;
  logic [PROB_BITS-1:0]   frac_q, frac_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic [DIV_CNT_W-1:0]   dcnt_q, dcnt_d;
  logic [IDX_W-1:0]       pick_q, pick_d;
  out_word_t              res_q, res_d;
  logic                   rv_q, rv_d;

  // Memory port signals.
  logic             sw_we, pay_we, rem_we, thr_we, ali_we;
  logic [IDX_W-1:0] sw_waddr, rem_waddr, thr_waddr, ali_waddr;
  logic [IDX_W-1:0] sw_raddr, pay_raddr, rem_raddr, thr_raddr, ali_raddr;
  logic [SW_W-1:0]  sw_wdata, sw_rdata, rem_wdata, rem_rdata;
  logic [VAL_W-1:0] pay_rdata;
  logic [WGT_W-1:0] thr_wdata, thr_rdata;
  logic [IDX_W-1:0] ali_wdata, ali_rdata;

  logic [WGT_W-1:0]       w_sat;
  logic [SW_W-1:0]        w_prod;
  logic [IDX_W-1:0]       ii, jj;
  logic [WGT_W-1:0]       give;
  logic [SW_W-1:0]        rem_new;
  logic [CNT_W-1:0]       div_r;
  logic [IDX_W-1:0]       pick_c;

  // Load arithmetic: saturate the weight and scale it by the entry count.
  assign w_sat  = (word_i.entry_weight > ONE_Q) ? ONE_Q : word_i.entry_weight;
  assign w_prod = SW_W'(w_sat) * SW_W'(n_q);

  assign ii = i_q[IDX_W-1:0];
  assign jj = j_q[IDX_W-1:0];

  // Donation from the heavy entry to a fixed entry, saturating at zero.
  assign give    = ONE_Q - thr_rdata;
  assign rem_new = (remi_q > SW_W'(give)) ? (remi_q - SW_W'(give)) : '0;

  // One restoring step of the remainder unit.
  always_comb begin
    div_r = {slot_q, rix_q[RIX_W-1]};
    if (div_r >= n_q) begin
      div_r = div_r - n_q;
    end
  end

  // Slot or its alias, depending on the fraction.
  assign pick_c = ({1'b0, frac_q} < thr_rdata) ? slot_q : ali_rdata;

  // Next state and sequencer registers.
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    built_d = built_q;
    fixed_d = fixed_q;
    aset_d  = aset_q;
    i_d     = i_q;
    j_d     = j_q;
    newly_d = newly_q;
    remi_d  = remi_q;
    rix_d   = rix_q;
    frac_d  = frac_q;
    slot_d  = slot_q;
    dcnt_d  = dcnt_q;
    pick_d  = pick_q;
    res_d   = res_q;
    rv_d    = 1'b0;

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        n_d = CNT_W'(1);
      end else if (cfg_wdata_i > CNT_W'(MAX_ENTRIES)) begin
        n_d = CNT_W'(MAX_ENTRIES);
      end else begin
        n_d = cfg_wdata_i;
      end
      built_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d = '0;
          unique case (word_i.cmd)
            CMD_LOAD: begin
              rv_d = 1'b1;
              if ({1'b0, word_i.entry_index} >= n_q) begin
                res_d.status = STAT_RANGE;
              end else begin
                built_d = 1'b0;
              end
            end
            CMD_BUILD: begin
              fixed_d = '0;
              aset_d  = '0;
              i_d     = '0;
              state_d = S_INIT_RD;
            end
            CMD_SAMPLE: begin
              if (!built_q) begin
                rv_d         = 1'b1;
                res_d.status = STAT_NOT_BUILT;
              end else begin
                rix_d   = word_i.rand_index;
                frac_d  = word_i.rand_frac;
                slot_d  = '0;
                dcnt_d  = '0;
                state_d = S_DIV;
              end
            end
            default: begin
              rv_d = 1'b1;
            end
          endcase
        end
      end
      S_INIT_RD: begin
        if (i_q == n_q) begin
          i_d     = '0;
          newly_d = 1'b0;
          state_d = S_A_RD;
        end else begin
          state_d = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        i_d     = i_q + 1'b1;
        state_d = S_INIT_RD;
      end
      S_A_RD: begin
        if (i_q == n_q) begin
          i_d     = '0;
          state_d = newly_q ? S_B_RD : S_FIN;
        end else begin
          state_d = S_A_EV;
        end
      end
      S_A_EV: begin
        if (!fixed_q[ii] && (rem_rdata <= SW_W'(ONE_Q))) begin
          fixed_d[ii] = 1'b1;
          newly_d     = 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = S_A_RD;
      end
      S_B_RD: begin
        if (i_q == n_q) begin
          i_d     = '0;
          newly_d = 1'b0;
          state_d = S_A_RD;
        end else begin
          state_d = S_B_EV;
        end
      end
      S_B_EV: begin
        if (rem_rdata > SW_W'(ONE_Q)) begin
          remi_d  = rem_rdata;
          j_d     = '0;
          state_d = S_B_J;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_B_RD;
        end
      end
      S_B_J: begin
        if (j_q == n_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_B_RD;
        end else if (fixed_q[jj] && !aset_q[jj]) begin
          state_d = S_B_G;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_B_G: begin
        aset_d[jj] = 1'b1;
        if (rem_new <= SW_W'(ONE_Q)) begin
          i_d     = i_q + 1'b1;
          state_d = S_B_RD;
        end else begin
          remi_d  = rem_new;
          j_d     = j_q + 1'b1;
          state_d = S_B_J;
        end
      end
      S_FIN: begin
        if (i_q == n_q) begin
          built_d = 1'b1;
          rv_d    = 1'b1;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_DIV: begin
        slot_d = div_r[IDX_W-1:0];
        rix_d  = rix_q << 1;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DIV_CNT_W'(RIX_W - 1)) begin
          state_d = S_SMP_RD;
        end
      end
      S_SMP_RD: begin
        state_d = S_SMP_PICK;
      end
      S_SMP_PICK: begin
        pick_d  = pick_c;
        state_d = S_SMP_OUT;
      end
      S_SMP_OUT: begin
        res_d.status       = STAT_OK;
        res_d.picked_index = pick_q;
        res_d.picked_value = pay_rdata;
        rv_d               = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory port controls.
  always_comb begin
    sw_we     = 1'b0;
    sw_waddr  = word_i.entry_index;
    sw_wdata  = w_prod;
    pay_we    = 1'b0;
    sw_raddr  = ii;
    rem_we    = 1'b0;
    rem_waddr = ii;
    rem_wdata = '0;
    rem_raddr = ii;
    thr_we    = 1'b0;
    thr_waddr = ii;
    thr_wdata = ONE_Q;
    thr_raddr = jj;
    ali_we    = 1'b0;
    ali_waddr = ii;
    ali_wdata = '0;
    ali_raddr = slot_q;
    pay_raddr = pick_c;

    unique case (state_q)
      S_IDLE: begin
        if (start_i && (word_i.cmd == CMD_LOAD) &&
            ({1'b0, word_i.entry_index} < n_q)) begin
          sw_we  = 1'b1;
          pay_we = 1'b1;
        end
      end
      S_INIT_WR: begin
        rem_we    = 1'b1;
        rem_wdata = sw_rdata;
      end
      S_A_EV: begin
        if (!fixed_q[ii] && (rem_rdata <= SW_W'(ONE_Q))) begin
          thr_we    = 1'b1;
          thr_wdata = rem_rdata[WGT_W-1:0];
          rem_we    = 1'b1;
        end
      end
      S_B_J: begin
        if (j_q == n_q) begin
          rem_we    = 1'b1;
          rem_wdata = remi_q;
        end
      end
      S_B_G: begin
        ali_we    = 1'b1;
        ali_waddr = jj;
        ali_wdata = ii;
        if (rem_new <= SW_W'(ONE_Q)) begin
          rem_we    = 1'b1;
          rem_wdata = rem_new;
        end
      end
      S_FIN: begin
        if ((i_q != n_q) && !aset_q[ii]) begin
          thr_we = 1'b1;
          ali_we = 1'b1;
        end
      end
      S_DIV, S_SMP_RD: begin
        thr_raddr = slot_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= CNT_W'(1);
      built_q <= 1'b0;
      fixed_q <= '0;
      aset_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      newly_q <= 1'b0;
      dcnt_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      built_q <= built_d;
      fixed_q <= fixed_d;
      aset_q  <= aset_d;
      i_q     <= i_d;
      j_q     <= j_d;
      newly_q <= newly_d;
      dcnt_q  <= dcnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remi_q <= remi_d;
    rix_q  <= rix_d;
    frac_q <= frac_d;
    slot_q <= slot_d;
    pick_q <= pick_d;
    res_q  <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_o       = res_q;
  assign result_valid_o = rv_q;

  // Scaled weights as loaded.
  atws_ram #(.WIDTH(SW_W), .DEPTH(MAX_ENTRIES)) u_sw_ram (
    .clk_i   (clk_i),
    .we_i    (sw_we),
    .waddr_i (sw_waddr),
    .wdata_i (sw_wdata),
    .raddr_i (sw_raddr),
    .rdata_o (sw_rdata)
  );

  // Payload words.
  atws_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (word_i.entry_index),
    .wdata_i (word_i.entry_value),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  // Remaining weights during a build.
  atws_ram #(.WIDTH(SW_W), .DEPTH(MAX_ENTRIES)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (rem_raddr),
    .rdata_o (rem_rdata)
  );

  // Thresholds.
  atws_ram #(.WIDTH(WGT_W), .DEPTH(MAX_ENTRIES)) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_waddr),
    .wdata_i (thr_wdata),
    .raddr_i (thr_raddr),
    .rdata_o (thr_rdata)
  );

  // Aliases.
  atws_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_ali_ram (
    .clk_i   (clk_i),
    .we_i    (ali_we),
    .waddr_i (ali_waddr),
    .wdata_i (ali_wdata),
    .raddr_i (ali_raddr),
    .rdata_o (ali_rdata)
  );

endmodule

`default_nettype wire
